@@ hdl/nrbf_pkg.sv @@
// Shared types and constants for the normalized RBF network evaluator.
// Holds the controller state type, the command and status structs, and the
// fixed-point constants. Depends on nothing.
package nrbf_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EVAL  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam int TBL_AW      = 8;
    localparam int TBL_DEPTH   = 256;
    localparam int EXP_STEPS   = 13;
    localparam int DIV_STEPS   = 15;
    localparam int RECIP_SHIFT = 27;

    localparam logic [20:0] RECIP_121 = 21'd1109237;
    localparam logic [19:0] A8_LIMIT  = 20'd991232;
    localparam logic [30:0] ONE_Q30   = 31'd1073741824;
    localparam logic [14:0] SAT_Q14   = 15'd16384;

    localparam logic [29:0] EXP_F [EXP_STEPS] = '{
        30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706262,
        30'd1008687096, 30'd947573834, 30'd836230973, 30'd651257337,
        30'd395007542, 30'd145315154, 30'd19666267, 30'd360200, 30'd121
    };

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DIST,
        S_SCALE,
        S_RECIP,
        S_CORR,
        S_EXPO,
        S_ACC,
        S_DPREP,
        S_DCHK,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              acc_in;
        logic              mem_clr;
        logic [TBL_AW-1:0] clr_addr;
        logic              dist_step;
        logic [1:0]        dim;
        logic              scale;
        logic              recip;
        logic              corr;
        logic              expo;
        logic [3:0]        exp_bit;
        logic              acc_step;
        logic              div_prep;
        logic              div_chk;
        logic              div_step;
        logic              fin_eval;
        logic              fin_read;
    } t_dp_cmd;

    typedef struct packed {
        logic last_basis;
    } t_dp_sts;

endpackage

@@ hdl/normalized_rbf_network_eval.sv @@
// Top level of the normalized Gaussian RBF network evaluator.
// Joins the controller nrbf_ctrl and the datapath nrbf_dp; uses nrbf_pkg.
//
// Usage: present a command on i_cmd with its fields and raise start. The
// transaction is accepted at a rising edge where start is high and busy is
// low. A weight write (command 0) and the unused command 3 are finished at
// acceptance and produce no result. A weight read (command 2) returns the
// stored weight with o_is_weight high; o_valid pulses for one cycle, rising in
// the cycle after the controller's read state.
// An evaluation (command 1) walks all BASIS_PER_DIM**DIMS bases one after
// another; each basis takes one step per dimension for the squared distance,
// the exponent scaling steps (scale, reciprocal, correction), one step per
// exponent bit for the exponent factor chain and one step to accumulate;
// a restoring division follows. One transaction is in work at a time.
// After reset the weight table is cleared in a pass over all TBL_DEPTH
// entries, during which busy is high. Results cannot be stalled: each is
// valid for exactly the cycle in which o_valid is high, and busy may already
// be low in that cycle.
module normalized_rbf_network_eval
    import nrbf_pkg::*;
#(
    parameter int BASIS_PER_DIM = 4,
    parameter int DIMS          = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_weight_index,
    input  logic signed [15:0] i_weight_value,
    input  logic signed [15:0] i_sensor_0,
    input  logic signed [15:0] i_sensor_1,
    input  logic signed [15:0] i_sensor_2,
    input  logic signed [15:0] i_sensor_3,
    output logic               o_valid,
    output logic signed [15:0] o_result_value,
    output logic               o_is_weight
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    nrbf_ctrl #(
        .DIMS(DIMS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_sts   (dp_sts),
        .o_dp_cmd(dp_cmd),
        .o_busy  (busy)
    );

    nrbf_dp #(
        .BASIS_PER_DIM(BASIS_PER_DIM),
        .DIMS         (DIMS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dp_cmd      (dp_cmd),
        .i_cmd         (i_cmd),
        .i_weight_index(i_weight_index),
        .i_weight_value(i_weight_value),
        .i_sensor_0    (i_sensor_0),
        .i_sensor_1    (i_sensor_1),
        .i_sensor_2    (i_sensor_2),
        .i_sensor_3    (i_sensor_3),
        .o_sts         (dp_sts),
        .o_valid       (o_valid),
        .o_result_value(o_result_value),
        .o_is_weight   (o_is_weight)
    );

endmodule

@@ hdl/nrbf_ctrl.sv @@
// Controller state machine of the normalized RBF network evaluator.
// Sequences the table clear, weight access, basis walk and final division.
// Depends on nrbf_pkg.
module nrbf_ctrl
    import nrbf_pkg::*;
#(
    parameter int DIMS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_cmd,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_dp_cmd,
    output logic       o_busy
);

    t_state            r_state, n_state;
    logic [TBL_AW-1:0] r_clr, n_clr;
    logic [1:0]        r_dim, n_dim;
    logic [3:0]        r_bit, n_bit;
    logic [3:0]        r_dstep, n_dstep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_dim   <= '0;
            r_bit   <= '0;
            r_dstep <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_dim   <= n_dim;
            r_bit   <= n_bit;
            r_dstep <= n_dstep;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_dim   = r_dim;
        n_bit   = r_bit;
        n_dstep = r_dstep;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == TBL_AW'(TBL_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_dim = '0;
                if (i_start) begin
                    case (i_cmd)
                        CMD_READ: n_state = S_READ;
                        CMD_EVAL: n_state = S_DIST;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: n_state = S_IDLE;
            S_DIST: begin
                n_dim = r_dim + 1'b1;
                if (r_dim == 2'(DIMS - 1)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_RECIP;
            S_RECIP: n_state = S_CORR;
            S_CORR: begin
                n_bit   = '0;
                n_state = S_EXPO;
            end
            S_EXPO: begin
                n_bit = r_bit + 1'b1;
                if (r_bit == 4'(EXP_STEPS - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_dim   = '0;
                n_state = i_sts.last_basis ? S_DPREP : S_DIST;
            end
            S_DPREP: n_state = S_DCHK;
            S_DCHK: begin
                n_dstep = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_dstep = r_dstep + 1'b1;
                if (r_dstep == 4'(DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_dp_cmd          = '0;
        o_dp_cmd.clr_addr = r_clr;
        o_dp_cmd.dim      = r_dim;
        o_dp_cmd.exp_bit  = r_bit;
        o_busy            = 1'b1;
        case (r_state)
            S_CLEAR: o_dp_cmd.mem_clr = 1'b1;
            S_IDLE: begin
                o_busy          = 1'b0;
                o_dp_cmd.acc_in = i_start;
            end
            S_READ:  o_dp_cmd.fin_read = 1'b1;
            S_DIST:  o_dp_cmd.dist_step = 1'b1;
            S_SCALE: o_dp_cmd.scale = 1'b1;
            S_RECIP: o_dp_cmd.recip = 1'b1;
            S_CORR:  o_dp_cmd.corr = 1'b1;
            S_EXPO:  o_dp_cmd.expo = 1'b1;
            S_ACC:   o_dp_cmd.acc_step = 1'b1;
            S_DPREP: o_dp_cmd.div_prep = 1'b1;
            S_DCHK:  o_dp_cmd.div_chk = 1'b1;
            S_DIV:   o_dp_cmd.div_step = 1'b1;
            S_FIN:   o_dp_cmd.fin_eval = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

endmodule

@@ hdl/nrbf_dp.sv @@
// Datapath of the normalized RBF network evaluator: weight memory, basis
// distance, exponent, activation, accumulators, divider and result register.
// Depends on nrbf_pkg.
module nrbf_dp
    import nrbf_pkg::*;
#(
    parameter int BASIS_PER_DIM = 4,
    parameter int DIMS          = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_dp_cmd,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_weight_index,
    input  logic signed [15:0] i_weight_value,
    input  logic signed [15:0] i_sensor_0,
    input  logic signed [15:0] i_sensor_1,
    input  logic signed [15:0] i_sensor_2,
    input  logic signed [15:0] i_sensor_3,
    output t_dp_sts            o_sts,
    output logic               o_valid,
    output logic signed [15:0] o_result_value,
    output logic               o_is_weight
);

    localparam int DIG_W   = $clog2(BASIS_PER_DIM);
    localparam int NB      = BASIS_PER_DIM ** DIMS;
    localparam int KW      = (NB > 2) ? $clog2(NB) : 1;
    localparam int SCALE_M = BASIS_PER_DIM * BASIS_PER_DIM * 50;

    logic signed [12:0] cen [BASIS_PER_DIM];

    for (genvar j = 0; j < BASIS_PER_DIM; j++) begin : g_cen
        localparam int CNUM = 4096 * j - 2048 * (BASIS_PER_DIM - 1);
        localparam int CMAG = (CNUM < 0) ? -CNUM : CNUM;
        localparam int CQ   = (2 * CMAG + BASIS_PER_DIM - 1) / (2 * (BASIS_PER_DIM - 1));
        localparam int CVAL = (CNUM < 0) ? -CQ : CQ;
        assign cen[j] = 13'(CVAL);
    end

    function automatic logic signed [16:0] wrap(input logic signed [15:0] v);
        logic [15:0]        t;
        logic signed [16:0] r;
        if (v > 16'sd4096) begin
            t = v - 16'sd4097;
            r = $signed({4'b0, t[12:0]}) - 17'sd4095;
        end else if (v < -16'sd4096) begin
            t = v + 16'sd4096;
            r = $signed({4'b0, t[12:0]}) - 17'sd4096;
        end else begin
            r = 17'(v);
        end
        return r;
    endfunction

    logic [15:0]        r_wt_mem [TBL_DEPTH];
    logic [15:0]        r_mem_rd;
    logic               mem_we;
    logic [TBL_AW-1:0]  mem_wa;
    logic [15:0]        mem_wd;
    logic               mem_re;
    logic [TBL_AW-1:0]  mem_ra;

    logic signed [16:0] r_x [4];
    logic signed [16:0] xin [4];
    logic signed [15:0] sin [4];
    logic [DIG_W-1:0]   r_dig [4];
    logic [DIG_W-1:0]   n_dig [4];
    logic [KW-1:0]      r_k;
    logic [32:0]        r_s;
    logic               r_zero;
    logic [19:0]        r_u;
    logic [12:0]        r_q0;
    logic [12:0]        r_a8;
    logic [30:0]        r_p;
    logic signed [59:0] r_num;
    logic [43:0]        r_den;
    logic [63:0]        r_rem;
    logic [63:0]        r_dv;
    logic [14:0]        r_q;
    logic               r_neg;
    logic               r_ovf;
    logic               r_valid;
    logic signed [15:0] r_res;
    logic               r_is_w;

    logic signed [17:0] diff;
    logic signed [35:0] sq;
    logic [44:0]        scaled;
    logic [28:0]        u_full;
    logic [40:0]        recip_prod;
    logic [20:0]        q0_chk;
    logic [20:0]        rem121;
    logic [60:0]        exp_prod;
    logic [60:0]        exp_rnd;
    logic signed [47:0] wp_prod;
    logic [59:0]        num_mag;
    logic [14:0]        q_mag;
    logic [15:0]        res_mag;
    logic               carry;

    assign sin[0] = i_sensor_0;
    assign sin[1] = i_sensor_1;
    assign sin[2] = i_sensor_2;
    assign sin[3] = i_sensor_3;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if ((i % 2 == 0) && (i < DIMS)) begin
                xin[i] = wrap(sin[i]);
            end else begin
                xin[i] = 17'(sin[i]);
            end
        end
        if (xin[0] < 0) begin
            for (int i = 0; i < 4; i++) begin
                xin[i] = -xin[i];
            end
        end
    end

    always_comb begin
        mem_we = i_dp_cmd.mem_clr || (i_dp_cmd.acc_in && (i_cmd == CMD_WRITE));
        mem_wa = i_dp_cmd.mem_clr ? i_dp_cmd.clr_addr : i_weight_index;
        mem_wd = i_dp_cmd.mem_clr ? 16'd0 : i_weight_value;
        mem_re = i_dp_cmd.acc_in || i_dp_cmd.dist_step;
        mem_ra = i_dp_cmd.dist_step ? TBL_AW'(r_k) : i_weight_index;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wt_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_rd <= r_wt_mem[mem_ra];
        end
    end

    always_comb begin
        carry = 1'b1;
        for (int i = 0; i < 4; i++) begin
            n_dig[i] = r_dig[i];
            if ((i < DIMS) && carry) begin
                if (r_dig[i] == DIG_W'(BASIS_PER_DIM - 1)) begin
                    n_dig[i] = '0;
                end else begin
                    n_dig[i] = r_dig[i] + 1'b1;
                    carry    = 1'b0;
                end
            end
        end
    end

    assign o_sts.last_basis = (r_k == KW'(NB - 1));

    always_comb begin
        diff       = 18'(r_x[i_dp_cmd.dim]) - 18'(cen[r_dig[i_dp_cmd.dim]]);
        sq         = diff * diff;
        scaled     = 45'(r_s) * 45'(SCALE_M);
        u_full     = scaled[44:16];
        recip_prod = 41'(r_u) * 41'(RECIP_121);
        q0_chk     = 21'(r_q0) * 21'd121;
        rem121     = 21'(r_u) - q0_chk;
        exp_prod   = 61'(r_p) * 61'(EXP_F[i_dp_cmd.exp_bit]);
        exp_rnd    = exp_prod + 61'(ONE_Q30 >> 1);
        wp_prod    = $signed(r_mem_rd) * $signed({17'd0, r_p});
        num_mag    = r_num[59] ? 60'(-r_num) : 60'(r_num);
        q_mag      = (r_ovf || (r_q > SAT_Q14)) ? SAT_Q14 : r_q;
        res_mag    = {1'b0, q_mag};
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.acc_in && (i_cmd == CMD_EVAL)) begin
            for (int i = 0; i < 4; i++) begin
                r_x[i]   <= xin[i];
                r_dig[i] <= '0;
            end
            r_k   <= '0;
            r_num <= '0;
            r_den <= 44'd1;
        end
        if (i_dp_cmd.dist_step) begin
            r_s <= ((i_dp_cmd.dim == 2'd0) ? 33'd0 : r_s) + 33'(sq[30:0]);
        end
        if (i_dp_cmd.scale) begin
            r_zero <= (u_full >= 29'(A8_LIMIT));
            r_u    <= u_full[19:0];
        end
        if (i_dp_cmd.recip) begin
            r_q0 <= recip_prod[RECIP_SHIFT+12:RECIP_SHIFT];
        end
        if (i_dp_cmd.corr) begin
            r_a8 <= r_q0 + 13'(rem121 >= 21'd121);
            r_p  <= r_zero ? 31'd0 : ONE_Q30;
        end
        if (i_dp_cmd.expo && r_a8[i_dp_cmd.exp_bit]) begin
            r_p <= exp_rnd[60:30];
        end
        if (i_dp_cmd.acc_step) begin
            r_num <= r_num + 60'(wp_prod);
            r_den <= r_den + 44'(r_p);
            r_k   <= r_k + 1'b1;
            for (int i = 0; i < 4; i++) begin
                r_dig[i] <= n_dig[i];
            end
        end
        if (i_dp_cmd.div_prep) begin
            r_rem <= {num_mag, 3'b000} + 64'(r_den);
            r_dv  <= 64'({r_den, 1'b0}) << 14;
            r_neg <= r_num[59];
            r_q   <= '0;
        end
        if (i_dp_cmd.div_chk) begin
            r_ovf <= (r_rem >= (r_dv << 1));
        end
        if (i_dp_cmd.div_step) begin
            if (r_rem >= r_dv) begin
                r_rem <= r_rem - r_dv;
                r_q   <= {r_q[13:0], 1'b1};
            end else begin
                r_q <= {r_q[13:0], 1'b0};
            end
            r_dv <= r_dv >> 1;
        end
        if (i_dp_cmd.fin_eval) begin
            r_res  <= r_neg ? $signed(-res_mag) : $signed(res_mag);
            r_is_w <= 1'b0;
        end
        if (i_dp_cmd.fin_read) begin
            r_res  <= $signed(r_mem_rd);
            r_is_w <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.fin_eval || i_dp_cmd.fin_read;
        end
    end

    assign o_valid        = r_valid;
    assign o_result_value = r_res;
    assign o_is_weight    = r_is_w;

endmodule

@@ sim/normalized_rbf_network_eval_chk.sv @@
// Checker for the normalized RBF network evaluator: watches accepted commands
// and result strobes, predicts each result and compares it. Uses nrbf_pkg.
`timescale 1ns / 1ps
module normalized_rbf_network_eval_chk
    import nrbf_pkg::*;
#(
    parameter int BASIS_PER_DIM = 4,
    parameter int DIMS          = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [7:0]         i_weight_index,
    input  logic signed [15:0] i_weight_value,
    input  logic signed [15:0] i_sensor_0,
    input  logic signed [15:0] i_sensor_1,
    input  logic signed [15:0] i_sensor_2,
    input  logic signed [15:0] i_sensor_3,
    input  logic               o_valid,
    input  logic signed [15:0] o_result_value,
    input  logic               o_is_weight,
    output int                 errors,
    output int                 pending,
    output int                 evals_seen,
    output int                 reads_seen
);

    typedef struct packed {
        logic signed [15:0] value;
        logic               is_weight;
    } t_result;

    logic signed [15:0] weights [TBL_DEPTH];
    t_result            expected_q [$];

    function automatic longint center_of(int j);
        longint den;
        longint num;
        longint mag;
        longint q;
        den = BASIS_PER_DIM - 1;
        num = 4096 * j - 2048 * den;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint unsigned gauss_of(longint unsigned s);
        longint unsigned a8;
        longint unsigned p;
        a8 = (s * BASIS_PER_DIM * BASIS_PER_DIM * 50 / 121) >> 16;
        if (a8 >= 8192) return 0;
        p = ONE_Q30;
        for (int b = 0; b < EXP_STEPS; b++)
            if (a8[b]) p = (p * longint'(EXP_F[b]) + (ONE_Q30 >> 1)) >> 30;
        return p;
    endfunction

    function automatic logic signed [15:0] network_out(logic signed [15:0] sv [4]);
        longint x [4];
        longint num;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned s;
        longint unsigned p;
        longint d;
        int nb;
        int r;
        int res;
        num = 0;
        den = 1;
        nb = 1;
        for (int i = 0; i < 4; i++) begin
            x[i] = sv[i];
            if (i % 2 == 0 && i < DIMS) begin
                while (x[i] > 4096) x[i] -= 8192;
                while (x[i] < -4096) x[i] += 8192;
            end
        end
        if (x[0] < 0)
            for (int i = 0; i < 4; i++) x[i] = -x[i];
        for (int i = 0; i < DIMS && i < 4; i++) nb *= BASIS_PER_DIM;
        for (int k = 0; k < nb; k++) begin
            r = k;
            s = 0;
            for (int i = 0; i < DIMS && i < 4; i++) begin
                d = x[i] - center_of(r % BASIS_PER_DIM);
                r /= BASIS_PER_DIM;
                s += d * d;
            end
            p = gauss_of(s);
            den += p;
            num += longint'(weights[k % TBL_DEPTH]) * longint'(p);
        end
        mag = ((num < 0) ? -num : num) * 4;
        q = (2 * mag + den) / (2 * den);
        if (q > 16384) q = 16384;
        res = (num < 0) ? -int'(q) : int'(q);
        return res[15:0];
    endfunction

    assign pending = expected_q.size();

    always_ff @(posedge i_clk) begin
        t_result exp_r;
        logic signed [15:0] sv [4];
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_DEPTH; i++) weights[i] <= '0;
            errors     <= 0;
            evals_seen <= 0;
            reads_seen <= 0;
            expected_q.delete();
        end else begin
            if (start && !busy) begin
                if (i_cmd == CMD_WRITE) begin
                    weights[i_weight_index] <= i_weight_value;
                end else if (i_cmd == CMD_READ) begin
                    expected_q.insert(expected_q.size(),
                                      t_result'{weights[i_weight_index], 1'b1});
                    reads_seen <= reads_seen + 1;
                end else if (i_cmd == CMD_EVAL) begin
                    sv = '{i_sensor_0, i_sensor_1, i_sensor_2, i_sensor_3};
                    expected_q.insert(expected_q.size(), t_result'{network_out(sv), 1'b0});
                    evals_seen <= evals_seen + 1;
                end
            end
            if (o_valid) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result value %0d is_weight %0b", $time,
                             o_result_value, o_is_weight);
                    errors <= errors + 1;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.value !== o_result_value || exp_r.is_weight !== o_is_weight) begin
                        $display("%0t: mismatch expected value %0d is_weight %0b, actual %0d %0b",
                                 $time, exp_r.value, exp_r.is_weight, o_result_value,
                                 o_is_weight);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

@@ sim/normalized_rbf_network_eval_tb.sv @@
// Testbench top for the normalized RBF network evaluator: drives directed and
// random commands, and gives the verdict. Uses nrbf_pkg and the checker.
`timescale 1ns / 1ps
module normalized_rbf_network_eval_tb;
    import nrbf_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_cmd;
    logic [7:0]         i_weight_index;
    logic signed [15:0] i_weight_value;
    logic signed [15:0] i_sensor_0;
    logic signed [15:0] i_sensor_1;
    logic signed [15:0] i_sensor_2;
    logic signed [15:0] i_sensor_3;
    logic               o_valid;
    logic signed [15:0] o_result_value;
    logic               o_is_weight;
    int                 errors;
    int                 pending;
    int                 evals_seen;
    int                 reads_seen;
    int                 items_sent;
    bit                 no_gaps;

    normalized_rbf_network_eval dut (.*);
    normalized_rbf_network_eval_chk chk (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("normalized_rbf_network_eval test failed");
        $finish;
    end

    task automatic send(logic [1:0] cmd, logic [7:0] idx, logic [15:0] wv,
                        logic [15:0] s0, logic [15:0] s1, logic [15:0] s2,
                        logic [15:0] s3);
        while (!no_gaps && $urandom_range(99) < 21) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_cmd          <= cmd;
        i_weight_index <= idx;
        i_weight_value <= wv;
        i_sensor_0     <= s0;
        i_sensor_1     <= s1;
        i_sensor_2     <= s2;
        i_sensor_3     <= s3;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    function automatic logic [15:0] rand_sensor();
        if ($urandom_range(99) < 60) return 16'($signed($urandom_range(0, 12288)) - 6144);
        return 16'($urandom);
    endfunction

    initial begin
        int pick;
        int drain;
        items_sent     = 0;
        no_gaps        = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = CMD_WRITE;
        i_weight_index = '0;
        i_weight_value = '0;
        i_sensor_0     = '0;
        i_sensor_1     = '0;
        i_sensor_2     = '0;
        i_sensor_3     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(CMD_READ, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send(CMD_EVAL, 8'd0, 16'h0, 16'h1000, 16'h0, 16'h0, 16'h0);
        send(CMD_WRITE, 8'd0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0);
        send(CMD_WRITE, 8'd255, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0);
        send(CMD_UNUSED, 8'd0, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0);
        send(CMD_READ, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send(CMD_READ, 8'd255, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        for (int i = 1; i < 255; i += 17)
            send(CMD_WRITE, 8'(i), 16'(i * 97), 16'h0, 16'h0, 16'h0, 16'h0);
        send(CMD_EVAL, 8'd0, 16'h0, 16'h1000, 16'h0, 16'hF000, 16'h0);
        send(CMD_EVAL, 8'd0, 16'h0, 16'hF000, 16'h0800, 16'h1000, 16'hF800);
        send(CMD_EVAL, 8'd0, 16'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send(CMD_EVAL, 8'd0, 16'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send(CMD_EVAL, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send(CMD_EVAL, 8'd0, 16'h0, 16'hFC00, 16'h0400, 16'h0, 16'hFC00);

        for (int n = 0; n < 480; n++) begin
            no_gaps = (n >= 200 && n < 300);
            pick = $urandom_range(99);
            if (pick < 45)
                send(CMD_WRITE, 8'($urandom), 16'($urandom), rand_sensor(), rand_sensor(),
                     rand_sensor(), rand_sensor());
            else if (pick < 83)
                send(CMD_READ, 8'($urandom), 16'($urandom), rand_sensor(), rand_sensor(),
                     rand_sensor(), rand_sensor());
            else if (pick < 96)
                send(CMD_EVAL, 8'($urandom), 16'($urandom), rand_sensor(), rand_sensor(),
                     rand_sensor(), rand_sensor());
            else
                send(CMD_UNUSED, 8'($urandom), 16'($urandom), rand_sensor(), rand_sensor(),
                     rand_sensor(), rand_sensor());
        end
        start <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < 20000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (6000) @(posedge i_clk);

        $display("Sent %0d commands; checked %0d evaluations and %0d weight reads.",
                 items_sent, evals_seen, reads_seen);
        if (errors == 0 && pending == 0) begin
            $display("normalized_rbf_network_eval test passed");
        end else begin
            $display("%0t: %0d mismatches, %0d results never arrived", $time, errors, pending);
            $display("normalized_rbf_network_eval test failed");
        end
        $finish;
    end

endmodule
